// ===== design/pfc_pkg.sv =====
package pfc_pkg;

	localparam int COMP_W = 10;
	localparam int CRC_W = 32;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

	typedef logic [CRC_W-1:0][CRC_W-1:0] crc_mat_t;

	typedef struct packed {
		logic [COMP_W-1:0] first_comp;
		logic [COMP_W-1:0] second_comp;
		logic [COMP_W-1:0] third_comp;
		logic              first_pixel;
		logic              last_pixel;
	} pix_item_t;

	// column i holds the register after shifting a lone bit i through 32 zero bits
	function automatic crc_mat_t crc_gen_cols();
		crc_mat_t              cols;
		logic [CRC_W-1:0]      v;
		logic                  top;
		for (int i = 0; i < CRC_W; i++) begin
			v = '0;
			v[i] = 1'b1;
			for (int k = 0; k < CRC_W; k++) begin
				top = v[CRC_W-1];
				v = {v[CRC_W-2:0], 1'b0};
				if (top)
					v = v ^ CRC_POLY;
			end
			cols[i] = v;
		end
		return cols;
	endfunction

	localparam crc_mat_t CRC_COLS = crc_gen_cols();

	// a full 32-bit word folded MSB first equals advancing (crc ^ word) by 32 zero bits
	function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
		input logic [CRC_W-1:0] word);
		logic [CRC_W-1:0] x;
		logic [CRC_W-1:0] acc;
		x = crc ^ word;
		acc = '0;
		for (int i = 0; i < CRC_W; i++) begin
			if (x[i])
				acc = acc ^ CRC_COLS[i];
		end
		return acc;
	endfunction

endpackage

// ===== design/pfc_if.sv =====
interface pfc_pix_if;
	logic                           valid;
	logic                           ready;
	logic [pfc_pkg::COMP_W-1:0]     first_comp;
	logic [pfc_pkg::COMP_W-1:0]     second_comp;
	logic [pfc_pkg::COMP_W-1:0]     third_comp;
	logic                           first_pixel;
	logic                           last_pixel;

	modport source (output valid, first_comp, second_comp, third_comp, first_pixel,
		last_pixel, input ready);
	modport sink (input valid, first_comp, second_comp, third_comp, first_pixel,
		last_pixel, output ready);
endinterface

interface pfc_crc_if;
	logic                           valid;
	logic                           ready;
	logic [pfc_pkg::CRC_W-1:0]      frame_crc;

	modport source (output valid, frame_crc, input ready);
	modport sink (input valid, frame_crc, output ready);
endinterface

// ===== design/pixel_frame_crc32_msb_first_top.sv =====
// Frame CRC-32 (MPEG-2 form: poly 0x04C11DB7, start all ones, no reflection, no final
// XOR) over a pixel stream, one pixel transaction per clock. Each pixel's three
// components are packed into a 32-bit word (YUV order, or VYU when component_order is
// set via cfg_we/cfg_wdata) and folded MSB first by a 32-bit parallel update. first_pixel
// restarts the CRC; a last_pixel transaction passes the input stage register, and its
// frame_crc is loaded into the output register once that is free; the CRC restarts
// after every frame. Pixels are taken every cycle; the input stalls only when a frame
// result is due while the previous one still waits in the output register. Change
// component_order only while idle.
module pixel_frame_crc32_msb_first_top #(
	parameter int COMPONENT_BITS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	pfc_pix_if.sink      pix,
	pfc_crc_if.source    crc
);

	logic                        valid_s1;
	pfc_pkg::pix_item_t          item_s1;
	logic                        advance;
	logic                        out_free;
	logic                        res_load;
	logic [pfc_pkg::CRC_W-1:0]   res_crc;

	pfc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pfc_crc_core #(
		.COMPONENT_BITS (COMPONENT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_free  (out_free),
		.advance   (advance),
		.res_load  (res_load),
		.res_crc   (res_crc)
	);

	pfc_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_load (res_load),
		.res_crc  (res_crc),
		.out_free (out_free),
		.crc      (crc)
	);

endmodule

// ===== design/pfc_in_stage.sv =====
module pfc_in_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	pfc_pix_if.sink              pix,
	input  logic                 advance,
	output logic                 valid_s1,
	output pfc_pkg::pix_item_t   item_s1
);

	assign pix.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			item_s1.first_comp  <= pix.first_comp;
			item_s1.second_comp <= pix.second_comp;
			item_s1.third_comp  <= pix.third_comp;
			item_s1.first_pixel <= pix.first_pixel;
			item_s1.last_pixel  <= pix.last_pixel;
		end
	end

endmodule

// ===== design/pfc_crc_core.sv =====
module pfc_crc_core #(
	parameter int COMPONENT_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_wdata,
	input  logic                        valid_s1,
	input  pfc_pkg::pix_item_t          item_s1,
	input  logic                        out_free,
	output logic                        advance,
	output logic                        res_load,
	output logic [pfc_pkg::CRC_W-1:0]   res_crc
);

	localparam int PACK_W = 3 * COMPONENT_BITS;

	logic                        order_q;
	logic [pfc_pkg::CRC_W-1:0]   crc_q;
	logic [pfc_pkg::CRC_W-1:0]   crc_base;
	logic [pfc_pkg::CRC_W-1:0]   word;
	logic [COMPONENT_BITS-1:0]   ca;
	logic [COMPONENT_BITS-1:0]   cb;
	logic [COMPONENT_BITS-1:0]   cc;
	logic [PACK_W-1:0]           packed_w;

	// narrower components keep their low bits only
	assign ca = item_s1.first_comp[COMPONENT_BITS-1:0];
	assign cb = item_s1.second_comp[COMPONENT_BITS-1:0];
	assign cc = item_s1.third_comp[COMPONENT_BITS-1:0];

	always_comb begin
		if (order_q)
			packed_w = {cc, ca, cb};
		else
			packed_w = {ca, cb, cc};
	end

	assign word     = pfc_pkg::CRC_W'(packed_w);
	assign crc_base = item_s1.first_pixel ? pfc_pkg::CRC_INIT : crc_q;
	assign res_crc  = pfc_pkg::crc_fold(crc_base, word);

	// a frame end waits for room in the output register; other pixels never stall
	assign advance  = valid_s1 && (!item_s1.last_pixel || out_free);
	assign res_load = advance && item_s1.last_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= pfc_pkg::CRC_INIT;
		end else if (advance) begin
			crc_q <= item_s1.last_pixel ? pfc_pkg::CRC_INIT : res_crc;
		end
	end

endmodule

// ===== design/pfc_out_stage.sv =====
module pfc_out_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        res_load,
	input  logic [pfc_pkg::CRC_W-1:0]   res_crc,
	output logic                        out_free,
	pfc_crc_if.source                   crc
);

	logic                        valid_s2;
	logic [pfc_pkg::CRC_W-1:0]   crc_s2;

	assign out_free      = !valid_s2 || crc.ready;
	assign crc.valid     = valid_s2;
	assign crc.frame_crc = crc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_load) begin
			valid_s2 <= 1'b1;
		end else if (crc.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load)
			crc_s2 <= res_crc;
	end

endmodule

// ===== design/pfc_checker.sv =====
module pfc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	input  logic                        pix_ready,
	input  logic                        pix_last,
	input  logic                        crc_valid,
	input  logic                        crc_ready,
	input  logic [pfc_pkg::CRC_W-1:0]   frame_crc
);

	// a pending result is held until its transaction completes
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		crc_valid && !crc_ready |=> crc_valid && $stable(frame_crc))
		else $error("frame_crc dropped or changed while stalled");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !crc_valid)
		else $error("result valid during reset");

	// a fresh result must trace back to a frame end accepted at the input
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(crc_valid) |-> $past(pix_valid && pix_ready && pix_last, 2))
		else $error("result without a preceding frame end");

	// pixel input only backs up behind a stalled result
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> crc_valid && !crc_ready)
		else $error("input stalled with output free");

endmodule

bind pixel_frame_crc32_msb_first_top pfc_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix.valid),
	.pix_ready (pix.ready),
	.pix_last  (pix.last_pixel),
	.crc_valid (crc.valid),
	.crc_ready (crc.ready),
	.frame_crc (crc.frame_crc)
);
